// ----- src/assert_macros.svh -----
// Assertion macros for the checker module of the packet receiver.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define DPR_ASSERT_CLK(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("%m: assertion failed");

// Clocked assertion on the local clk and rst_n.
`define DPR_ASSERT(label, prop) `DPR_ASSERT_CLK(label, clk, rst_n, prop)

`endif

// ----- src/dpr_pkg.sv -----
// Shared constants, command types and a helper function of the packet receiver.
// Depends on nothing; used by the interfaces and all receiver modules.
package dpr_pkg;

    localparam int BUFFER_DEPTH = 2048;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = 11;
    localparam int INDEX_W      = 11;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] HEX_BAD  = 8'hFF;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_NAK     = 3'd2,
        OP_ACK     = 3'd3,
        OP_ACK_SEQ = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [7:0]        seq1;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // Value of a checksum character; anything that is not hex reads as -1.
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = HEX_BAD;
        end
        return v;
    endfunction

endpackage

// ----- src/dpr_stream_if.sv -----
// Valid/ready channel interfaces for input items and result beats.
// Depends on dpr_pkg for field widths.
interface dpr_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [7:0]                     rx_byte;
    logic [dpr_pkg::INDEX_W-1:0]    read_index;

    modport source (output valid, kind, rx_byte, read_index, input ready);
    modport sink (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface dpr_out_if;
    logic                           valid;
    logic                           ready;
    logic                           tx_valid;
    logic [7:0]                     tx_byte;
    logic                           packet_ready;
    logic [1:0]                     payload_offset;
    logic [dpr_pkg::LEN_W-1:0]      payload_length;
    logic [7:0]                     read_data;
    logic                           last;

    modport source (output valid, tx_valid, tx_byte, packet_ready, payload_offset,
                    payload_length, read_data, last, input ready);
    modport sink (input valid, tx_valid, tx_byte, packet_ready, payload_offset,
                  payload_length, read_data, last, output ready);
endinterface

// ----- src/dpr_front.sv -----
// Front end: accepts input items, tracks the packet framing and checksum,
// and turns items into commands for the back end. Depends on dpr_pkg.
module dpr_front (
    input  logic             clk,
    input  logic             rst_n,
    dpr_in_if.sink           in_port,
    input  logic             q_full,
    output logic             push,
    output dpr_pkg::cmd_t    push_cmd
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_DATA = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [7:0]                 run_sum_reg, run_sum_next;
    logic [7:0]                 rcv_sum_reg, rcv_sum_next;
    logic [dpr_pkg::ADDR_W-1:0] count_reg, count_next;
    logic [7:0]                 byte0_reg, byte0_next;
    logic [7:0]                 byte1_reg, byte1_next;
    logic [7:0]                 byte2_reg, byte2_next;
    logic                       accept;
    logic [7:0]                 c;
    logic [7:0]                 hex_c;
    logic [7:0]                 total;

    assign in_port.ready = !q_full;
    assign accept        = in_port.valid && in_port.ready;
    assign c             = in_port.rx_byte;
    assign hex_c         = dpr_pkg::hex_value(c);
    assign total         = rcv_sum_reg + hex_c;

    always_comb
    begin
        phase_next   = phase_reg;
        run_sum_next = run_sum_reg;
        rcv_sum_next = rcv_sum_reg;
        count_next   = count_reg;
        byte0_next   = byte0_reg;
        byte1_next   = byte1_reg;
        byte2_next   = byte2_reg;
        push         = 1'b0;
        push_cmd     = '0;
        if (accept)
        begin
            if (in_port.kind)
            begin
                push          = 1'b1;
                push_cmd.op   = dpr_pkg::OP_READ;
                push_cmd.addr = dpr_pkg::ADDR_W'(in_port.read_index);
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (c == dpr_pkg::CH_START)
                        begin
                            phase_next   = PH_DATA;
                            run_sum_next = '0;
                            count_next   = '0;
                        end
                    end
                    PH_DATA:
                    begin
                        if (c == dpr_pkg::CH_START)
                        begin
                            run_sum_next = '0;
                            count_next   = '0;
                        end
                        else if (c == dpr_pkg::CH_HASH)
                        begin
                            phase_next = PH_HI;
                        end
                        else
                        begin
                            run_sum_next  = run_sum_reg + c;
                            push          = 1'b1;
                            push_cmd.op   = dpr_pkg::OP_WRITE;
                            push_cmd.addr = count_reg;
                            push_cmd.data = c;
                            if (count_reg == dpr_pkg::ADDR_W'(0))
                            begin
                                byte0_next = c;
                            end
                            if (count_reg == dpr_pkg::ADDR_W'(1))
                            begin
                                byte1_next = c;
                            end
                            if (count_reg == dpr_pkg::ADDR_W'(2))
                            begin
                                byte2_next = c;
                            end
                            count_next = count_reg + dpr_pkg::ADDR_W'(1);
                            if (count_reg == dpr_pkg::ADDR_W'(dpr_pkg::BUFFER_DEPTH - 2))
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                    end
                    PH_HI:
                    begin
                        rcv_sum_next = {hex_c[3:0], 4'h0};
                        phase_next   = PH_LO;
                    end
                    PH_LO:
                    begin
                        rcv_sum_next = total;
                        phase_next   = PH_HUNT;
                        push         = 1'b1;
                        push_cmd.len = dpr_pkg::LEN_W'(count_reg);
                        if (total != run_sum_reg)
                        begin
                            push_cmd.op  = dpr_pkg::OP_NAK;
                            push_cmd.len = '0;
                        end
                        else if (count_reg >= dpr_pkg::ADDR_W'(3)
                                 && byte2_reg == dpr_pkg::CH_COLON)
                        begin
                            push_cmd.op   = dpr_pkg::OP_ACK_SEQ;
                            push_cmd.data = byte0_reg;
                            push_cmd.seq1 = byte1_reg;
                        end
                        else
                        begin
                            push_cmd.op = dpr_pkg::OP_ACK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            run_sum_reg <= '0;
            rcv_sum_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            run_sum_reg <= run_sum_next;
            rcv_sum_reg <= rcv_sum_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
        byte2_reg <= byte2_next;
    end

endmodule

// ----- src/dpr_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on dpr_pkg for the command type and the queue depth.
module dpr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dpr_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output dpr_pkg::cmd_t    head
);

    dpr_pkg::cmd_t                   entry_reg [dpr_pkg::QUEUE_DEPTH];
    logic [dpr_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dpr_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dpr_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = count_reg == dpr_pkg::QUEUE_CNT_W'(dpr_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == dpr_pkg::QUEUE_PTR_W'(dpr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + dpr_pkg::QUEUE_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == dpr_pkg::QUEUE_PTR_W'(dpr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + dpr_pkg::QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + dpr_pkg::QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - dpr_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/dpr_back.sv -----
// Back end: executes queued commands, owns the payload store, and drives
// the registered result channel. Depends on dpr_pkg and dpr_out_if.
module dpr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  dpr_pkg::cmd_t    head,
    output logic             pop,
    dpr_out_if.source        out_port
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEQ0 = 3'b010,
        ST_SEQ1 = 3'b100
    } state_t;

    logic [7:0]                 mem [dpr_pkg::BUFFER_DEPTH];
    logic [7:0]                 mem_rd_reg;
    logic                       wr_en;
    logic                       rd_en;

    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       tx_valid_reg, tx_valid_next;
    logic [7:0]                 tx_byte_reg, tx_byte_next;
    logic                       pkt_ready_reg, pkt_ready_next;
    logic [1:0]                 offset_reg, offset_next;
    logic [dpr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       last_reg, last_next;
    logic                       is_read_reg, is_read_next;
    logic [7:0]                 seq0_reg, seq0_next;
    logic [7:0]                 seq1_reg, seq1_next;
    logic [dpr_pkg::LEN_W-1:0]  seq_len_reg, seq_len_next;
    logic                       load;
    logic                       emit;

    assign load = !out_valid_reg || out_port.ready;

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        emit           = 1'b0;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        pkt_ready_next = pkt_ready_reg;
        offset_next    = offset_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        is_read_next   = is_read_reg;
        seq0_next      = seq0_reg;
        seq1_next      = seq1_reg;
        seq_len_next   = seq_len_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid) begin
                    if (head.op == dpr_pkg::OP_WRITE) begin
                        pop   = 1'b1;
                        wr_en = 1'b1;
                    end else if (load) begin
                        pop            = 1'b1;
                        emit           = 1'b1;
                        tx_valid_next  = 1'b1;
                        tx_byte_next   = dpr_pkg::CH_ACK;
                        pkt_ready_next = 1'b0;
                        offset_next    = 2'd0;
                        len_next       = '0;
                        last_next      = 1'b1;
                        is_read_next   = 1'b0;
                        case (head.op)
                            dpr_pkg::OP_READ:
                            begin
                                rd_en         = 1'b1;
                                tx_valid_next = 1'b0;
                                tx_byte_next  = 8'h00;
                                is_read_next  = 1'b1;
                            end
                            dpr_pkg::OP_NAK:
                            begin
                                tx_byte_next = dpr_pkg::CH_NAK;
                            end
                            dpr_pkg::OP_ACK:
                            begin
                                pkt_ready_next = 1'b1;
                                len_next       = head.len;
                            end
                            dpr_pkg::OP_ACK_SEQ:
                            begin
                                last_next    = 1'b0;
                                seq0_next    = head.data;
                                seq1_next    = head.seq1;
                                seq_len_next = head.len;
                                state_next   = ST_SEQ0;
                            end
                            default:
                            begin
                                tx_byte_next = dpr_pkg::CH_NAK;
                            end
                        endcase
                    end
                end
            end
            ST_SEQ0:
            begin
                if (load) begin
                    emit          = 1'b1;
                    tx_valid_next = 1'b1;
                    tx_byte_next  = seq0_reg;
                    last_next     = 1'b0;
                    is_read_next  = 1'b0;
                    state_next    = ST_SEQ1;
                end
            end
            ST_SEQ1:
            begin
                if (load) begin
                    emit           = 1'b1;
                    tx_valid_next  = 1'b1;
                    tx_byte_next   = seq1_reg;
                    pkt_ready_next = 1'b1;
                    offset_next    = 2'd3;
                    len_next       = seq_len_reg;
                    last_next      = 1'b1;
                    is_read_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_port.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg  <= tx_valid_next;
        tx_byte_reg   <= tx_byte_next;
        pkt_ready_reg <= pkt_ready_next;
        offset_reg    <= offset_next;
        len_reg       <= len_next;
        last_reg      <= last_next;
        is_read_reg   <= is_read_next;
        seq0_reg      <= seq0_next;
        seq1_reg      <= seq1_next;
        seq_len_reg   <= seq_len_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[head.addr] <= head.data;
        end
        if (rd_en) begin
            mem_rd_reg <= mem[head.addr];
        end
    end

    assign out_port.valid          = out_valid_reg;
    assign out_port.tx_valid       = tx_valid_reg;
    assign out_port.tx_byte        = tx_byte_reg;
    assign out_port.packet_ready   = pkt_ready_reg;
    assign out_port.payload_offset = offset_reg;
    assign out_port.payload_length = len_reg;
    assign out_port.read_data      = is_read_reg ? mem_rd_reg : 8'h00;
    assign out_port.last           = last_reg;

endmodule

// ----- src/debug_packet_receiver.sv -----
// Top level of the serial debug packet receiver: front end, command queue
// and back end. Depends on dpr_pkg, dpr_stream_if, dpr_front, dpr_queue, dpr_back.

// The receiver takes one input item per clock while the command queue has
// room; a byte that ends a packet or a store read is registered as a command
// in the queue, and the back end then loads its first result beat into the
// output register when that register is empty or its beat is being taken.
// An acknowledged packet with a sequence id occupies the output for three
// beats, and the four-entry queue absorbs items arriving meanwhile.
// Payload writes and reads share the single-port store in the back end, one
// access per cycle. Reading a store entry that was never written returns an
// unspecified byte.
module debug_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    dpr_in_if.sink      in_port,
    dpr_out_if.source   out_port
);

    logic             push;
    dpr_pkg::cmd_t    push_cmd;
    logic             pop;
    logic             q_full;
    logic             head_valid;
    dpr_pkg::cmd_t    head;

    dpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_port  (in_port),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    dpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_port   (out_port)
    );

endmodule

// ----- src/dpr_checker.sv -----
// Port-level checks on the result channel of the packet receiver, bound to
// the top level. Depends on assert_macros.svh and debug_packet_receiver.
`include "assert_macros.svh"

module dpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        tx_valid,
    input logic [7:0]  tx_byte,
    input logic        packet_ready,
    input logic [1:0]  payload_offset,
    input logic        last
);

    // A stalled beat stays offered with the same byte.
    `DPR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(tx_byte))

    // The beats of a sequence echo follow one another without a gap.
    `DPR_ASSERT(a_seq_no_gap, out_valid && out_ready && !last |=> out_valid)

    // A packet is reported only on the final transmit beat.
    `DPR_ASSERT(a_ready_final, out_valid && packet_ready |-> last && tx_valid)

    // A nonzero offset belongs to an accepted packet.
    `DPR_ASSERT(a_offset_pkt, out_valid && payload_offset != 2'd0 |-> packet_ready)

    // Read results carry no transmit character and end their item.
    `DPR_ASSERT(a_read_single, out_valid && !tx_valid |-> last && tx_byte == 8'h00)

endmodule

bind debug_packet_receiver dpr_checker u_dpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_port.valid),
    .out_ready      (out_port.ready),
    .tx_valid       (out_port.tx_valid),
    .tx_byte        (out_port.tx_byte),
    .packet_ready   (out_port.packet_ready),
    .payload_offset (out_port.payload_offset),
    .last           (out_port.last)
);
